[hdl/btms_pkg.sv]
// Package for the band trimmed mean scaler.
// Holds field widths, fixed constants, register indexes and the divider status type.
// No dependencies.
package btms_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int GAIN_W     = 8;
    localparam int THR_W      = 12;
    localparam int MIN_W      = 13;
    localparam int SPAN_W     = 13;
    localparam int BAND_OUT_W = 3;
    localparam int LEVEL_W    = 8;
    localparam int PROD_W     = 20;

    localparam int FULL_SCALE = 4096;
    localparam int LEVEL_MAX  = 255;

    localparam int DEF_NUM_SWEEPS = 5;
    localparam int DEF_NUM_BANDS  = 7;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd1;
    localparam logic [THR_W-1:0]  THR_RESET  = 12'd0;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[hdl/btms_acc_mem.sv]
// Per-band accumulator memory: sum, minimum and maximum of each band.
// One write port, one registered read port, per-entry valid bits; uses btms_pkg.
module btms_acc_mem
    import btms_pkg::*;
#(
    parameter int NUM_BANDS = DEF_NUM_BANDS,
    parameter int SUM_W     = SAMPLE_W + 3,
    parameter int ADDR_W    = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_rd_en,
    input  logic [ADDR_W-1:0]                  i_rd_addr,
    input  logic                               i_wr_en,
    input  logic                               i_clr_en,
    input  logic [ADDR_W-1:0]                  i_wr_addr,
    input  logic [SUM_W+MIN_W+SAMPLE_W-1:0]    i_wr_data,
    output logic [SUM_W+MIN_W+SAMPLE_W-1:0]    o_rd_data
);

    localparam int ENT_W = SUM_W + MIN_W + SAMPLE_W;
    localparam logic [ENT_W-1:0] EMPTY_ENTRY =
        {SUM_W'(0), MIN_W'(FULL_SCALE), SAMPLE_W'(0)};

    logic [ENT_W-1:0]     r_mem [NUM_BANDS];
    logic [NUM_BANDS-1:0] r_vld;
    logic [ENT_W-1:0]     r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // An entry that was never written since reset or its last clear reads as empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end else if (i_clr_en) begin
                r_vld[i_wr_addr] <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : EMPTY_ENTRY;

endmodule

[hdl/btms_div.sv]
// Restoring divider, one quotient bit per cycle.
// Used by the level mapping; uses btms_pkg.
module btms_div
    import btms_pkg::*;
#(
    parameter int DVD_W = PROD_W,
    parameter int DVS_W = SPAN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             q_bit;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        q_bit = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], q_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

[hdl/band_trimmed_mean_scaler_core.sv]
// Band trimmed mean scaler, top level. Uses btms_pkg, btms_acc_mem and btms_div.
// A sample outside the final sweep takes a memory read, then a write-back; no new sample
// is taken until it is through. A final-sweep sample goes through trim and entry clear,
// reciprocal multiply for the mean, gain, scaling, then a one bit per cycle span divide.
// A stalled output holds the core until its result is taken.
// Reset (synchronous, active low) restores gain 1, threshold 0, band and sweep 0, and
// marks every band entry empty at once, so no clearing pass is needed.
module band_trimmed_mean_scaler_core
    import btms_pkg::*;
#(
    parameter int NUM_SWEEPS = DEF_NUM_SWEEPS,
    parameter int NUM_BANDS  = DEF_NUM_BANDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [BAND_OUT_W-1:0] o_band,
    output logic [LEVEL_W-1:0]    o_level,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int SWP_W  = $clog2(NUM_SWEEPS);
    localparam int SUM_W  = SAMPLE_W + $clog2(NUM_SWEEPS);
    localparam int ENT_W  = SUM_W + MIN_W + SAMPLE_W;
    localparam int DVD_W  = PROD_W;

    // Division by the fixed trim count is a multiply by a rounded-up reciprocal.
    localparam int TRIM_D   = NUM_SWEEPS - 2;
    localparam int RECIP_SH = SUM_W + $clog2(TRIM_D);
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int MPROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(TRIM_D) - 64'd1) / 64'(TRIM_D));

    localparam logic [BAND_W-1:0] BAND_LAST  = BAND_W'(NUM_BANDS - 1);
    localparam logic [SWP_W-1:0]  SWP_LAST   = SWP_W'(NUM_SWEEPS - 1);
    localparam logic [SPAN_W-1:0] FULL_SPAN  = SPAN_W'(FULL_SCALE);
    localparam logic [PROD_W-1:0] FULL_PROD  = PROD_W'(FULL_SCALE);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UPD    = 4'd1;
    localparam logic [3:0] S_MEAN   = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_SCL    = 4'd4;
    localparam logic [3:0] S_LSTART = 4'd5;
    localparam logic [3:0] S_LWAIT  = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;

    logic [3:0]          r_state, n_state;
    logic [BAND_W-1:0]   r_band_cnt;
    logic [SWP_W-1:0]    r_swp_cnt;
    logic [BAND_W-1:0]   r_band;
    logic                r_final;
    logic [SAMPLE_W-1:0] r_sample;
    logic [GAIN_W-1:0]   r_gain;
    logic [THR_W-1:0]    r_thr;
    logic [SUM_W-1:0]    r_trim;
    logic [SAMPLE_W-1:0] r_mean;
    logic [PROD_W-1:0]   r_prod;
    logic [DVD_W-1:0]    r_scaled;
    logic [SPAN_W-1:0]   r_span;
    logic                r_out_valid;
    logic [BAND_OUT_W-1:0] r_out_band;
    logic [LEVEL_W-1:0]  r_out_level;
    logic                r_out_last;

    logic                accept;
    logic [ENT_W-1:0]    rd_data;
    logic [ENT_W-1:0]    wr_data;
    logic                wr_en;
    logic                clr_en;
    logic [SUM_W-1:0]    old_sum, new_sum, trim;
    logic [MIN_W-1:0]    old_min, new_min;
    logic [SAMPLE_W-1:0] old_max, new_max;
    logic [MPROD_W-1:0]  mean_prod;
    logic [MIN_W-1:0]    clamped;
    logic [MIN_W-1:0]    span_off;
    logic [PROD_W:0]     times_max;
    logic [BAND_W+BAND_OUT_W-1:0] band_ext;
    logic                out_load;

    logic                div_start;
    logic [DVD_W-1:0]    div_dividend;
    logic [SPAN_W-1:0]   div_divisor;
    t_div_stat           div_stat;
    logic [DVD_W-1:0]    div_quo;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_thr  <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN:      r_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_THRESHOLD: r_thr  <= i_cfg_data[THR_W-1:0];
                default:       ;
            endcase
        end
    end

    btms_acc_mem #(
        .NUM_BANDS (NUM_BANDS),
        .SUM_W     (SUM_W),
        .ADDR_W    (BAND_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (r_band_cnt),
        .i_wr_en   (wr_en),
        .i_clr_en  (clr_en),
        .i_wr_addr (r_band),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // Read-modify-write of the band entry; the final sweep clears it instead.
    always_comb begin
        old_sum = rd_data[ENT_W-1 -: SUM_W];
        old_min = rd_data[SAMPLE_W +: MIN_W];
        old_max = rd_data[SAMPLE_W-1:0];
        new_sum = old_sum + SUM_W'(r_sample);
        new_min = ({1'b0, r_sample} < old_min) ? {1'b0, r_sample} : old_min;
        new_max = (r_sample > old_max) ? r_sample : old_max;
        trim    = new_sum - SUM_W'(new_min) - SUM_W'(new_max);
        wr_data = {new_sum, new_min, new_max};
        wr_en   = (r_state == S_UPD) && !r_final;
        clr_en  = (r_state == S_UPD) && r_final;
    end

    assign mean_prod = MPROD_W'(r_trim) * MPROD_W'(RECIP);

    // Clamp to [threshold, full scale] and scale the offset by 255.
    always_comb begin
        if (r_prod < PROD_W'(r_thr)) begin
            clamped = {1'b0, r_thr};
        end else if (r_prod > FULL_PROD) begin
            clamped = FULL_SPAN;
        end else begin
            clamped = r_prod[MIN_W-1:0];
        end
        span_off  = clamped - {1'b0, r_thr};
        times_max = (PROD_W+1)'({span_off, 8'b0}) - (PROD_W+1)'(span_off);
    end

    assign div_start    = (r_state == S_LSTART);
    assign div_dividend = r_scaled;
    assign div_divisor  = r_span;

    btms_div #(
        .DVD_W (DVD_W),
        .DVS_W (SPAN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (accept) n_state = S_UPD;
            S_UPD:    n_state = r_final ? S_MEAN : S_IDLE;
            S_MEAN:   n_state = S_MUL;
            S_MUL:    n_state = S_SCL;
            S_SCL:    n_state = S_LSTART;
            S_LSTART: n_state = S_LWAIT;
            S_LWAIT:  if (div_stat.done) n_state = S_OUT;
            S_OUT:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_band_cnt  <= '0;
            r_swp_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (r_band_cnt == BAND_LAST) begin
                    r_band_cnt <= '0;
                    r_swp_cnt  <= (r_swp_cnt == SWP_LAST) ? '0 : r_swp_cnt + 1'b1;
                end else begin
                    r_band_cnt <= r_band_cnt + 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign band_ext = {{BAND_OUT_W{1'b0}}, r_band};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_band   <= r_band_cnt;
            r_final  <= (r_swp_cnt == SWP_LAST);
            r_sample <= i_sample;
        end
        if (r_state == S_UPD) begin
            r_trim <= trim;
        end
        if (r_state == S_MEAN) begin
            r_mean <= mean_prod[RECIP_SH +: SAMPLE_W];
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_mean) * PROD_W'(r_gain);
        end
        if (r_state == S_SCL) begin
            r_scaled <= DVD_W'(times_max[PROD_W-1:0]);
            r_span   <= FULL_SPAN - {1'b0, r_thr};
        end
        if (out_load) begin
            r_out_band  <= band_ext[BAND_OUT_W-1:0];
            r_out_level <= div_quo[LEVEL_W-1:0];
            r_out_last  <= (r_band == BAND_LAST);
        end
    end

    assign o_valid = r_out_valid;
    assign o_band  = r_out_band;
    assign o_level = r_out_level;
    assign o_last  = r_out_last;

    // An accepted request always goes to the entry update next.
    a_accept_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_UPD))
        else $error("accepted request did not enter the update state");

    // The divider is never restarted while it still works.
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // No new request is taken while the divider is still working.
    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_stat.busy)
        else $error("idle with divider busy");

    // The mapping span is never zero when the level divide starts.
    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LSTART) |-> (r_span != '0))
        else $error("zero span at level divide");

endmodule
